FILE: rtl/core/stq_pkg.sv
// stq_pkg: shared types and constants of the sorted timer event queue.
// No dependencies; used by the interfaces, stq_cell and the top level.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int TICK_W = 64;
  localparam int FREQ_W = 32;
  localparam int TAG_W  = 8;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd62500000;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  // command broadcast to every cell of the queue
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [TICK_W-1:0] new_deadline;
    logic [TAG_W-1:0]  new_tag;
  } stq_cmd_t;

endpackage

FILE: rtl/core/stq_if.sv
// stq_req_if / stq_rsp_if: valid/ready channels of the timer queue.
// Depends on stq_pkg for field widths.
`timescale 1ns / 1ps

interface stq_req_if;
  import stq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [FREQ_W-1:0] timeout;
  logic              in_ticks;
  logic [TAG_W-1:0]  event_tag;

  modport source (output valid, req_type, timeout, in_ticks, event_tag, input ready);
  modport sink   (input valid, req_type, timeout, in_ticks, event_tag, output ready);
endinterface

interface stq_rsp_if #(
  parameter int CNT_W = 5
);
  import stq_pkg::*;

  logic              valid;
  logic              ready;
  logic              fired;
  logic [TAG_W-1:0]  fired_tag;
  logic [TICK_W-1:0] next_compare;
  logic [CNT_W-1:0]  queued_count;
  logic              rejected;

  modport source (output valid, fired, fired_tag, next_compare, queued_count, rejected,
                  input ready);
  modport sink   (input valid, fired, fired_tag, next_compare, queued_count, rejected,
                  output ready);
endinterface

FILE: rtl/core/sorted_timer_event_queue_unit.sv
// sorted_timer_event_queue_unit: tick counter, compare register and a
// deadline-sorted chain of stq_cell slots. Uses stq_pkg, stq_if, stq_cell.
`timescale 1ns / 1ps
//
//  channel  dir  fields
//  req      in   req_type, timeout, in_ticks, event_tag
//  rsp      out  fired, fired_tag, next_compare, queued_count, rejected
//  cfg      in   cfg_we, cfg_wdata (tick_frequency)
//
//  One request at a time. An add runs multiply, add and insert into the
//  cell chain before its result; a full-queue add goes straight to result.
//  A tick bumps and tests; an idle reload of compare goes through the shared
//  32x32 multiplier. rsp is a register: the next beat is accepted while a
//  result waits, but a result stalls in place until rsp slot is free.
//  rst clears counter, compare (all ones), count and handshakes.

module sorted_timer_event_queue_unit #(
  parameter int QUEUE_DEPTH         = 16,
  parameter int IDLE_RELOAD_SECONDS = 10000
) (
  input  logic                        clk,
  input  logic                        rst,
  stq_req_if.sink                     req,
  stq_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [stq_pkg::FREQ_W-1:0]  cfg_wdata
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_BUMP  = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [FREQ_W-1:0] RELOAD_SEC = FREQ_W'(IDLE_RELOAD_SECONDS);
  localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);

  logic [2:0]        state;
  logic [FREQ_W-1:0] freq;
  logic [TICK_W-1:0] now;
  logic [TICK_W-1:0] compare;
  logic [CNT_W-1:0]  count;

  // latched request
  logic              is_add;
  logic [FREQ_W-1:0] timeout_r;
  logic              ticks_r;
  logic [TAG_W-1:0]  tag_r;

  // datapath registers
  logic [TICK_W-1:0] prod;
  logic [TICK_W-1:0] dl;

  // result staging
  logic              fired_r;
  logic [TAG_W-1:0]  fired_tag_r;
  logic              rejected_r;

  logic [FREQ_W-1:0] mul_b;
  logic [TICK_W-1:0] mul_p;
  logic              due;
  logic              rsp_free;
  stq_cmd_t          cmd;

  logic [QUEUE_DEPTH-1:0] cell_place;
  logic [TICK_W-1:0]      cell_dl  [QUEUE_DEPTH];
  logic [TAG_W-1:0]       cell_tag [QUEUE_DEPTH];

  // shared multiplier operands
  assign mul_b    = is_add ? timeout_r : RELOAD_SEC;
  assign mul_p    = freq * mul_b;
  assign due      = now >= compare;
  assign rsp_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // command to the cell chain
  always_comb begin
    cmd.insert       = (state == S_PLACE);
    cmd.pop          = (state == S_TEST) && due && (count != '0);
    cmd.new_deadline = dl;
    cmd.new_tag      = tag_r;
  end

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              lp;
    logic [TICK_W-1:0] ld;
    logic [TAG_W-1:0]  lt;
    logic [TICK_W-1:0] rd;
    logic [TAG_W-1:0]  rt;

    if (i == 0) begin : g_head
      assign lp = 1'b0;
      assign ld = '0;
      assign lt = '0;
    end else begin : g_body
      assign lp = cell_place[i-1];
      assign ld = cell_dl[i-1];
      assign lt = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rd = '0;
      assign rt = '0;
    end else begin : g_next
      assign rd = cell_dl[i+1];
      assign rt = cell_tag[i+1];
    end

    stq_cell u_cell (
      .clk            (clk),
      .cmd            (cmd),
      .occupied       (CNT_W'(i) < count),
      .left_place     (lp),
      .left_deadline  (ld),
      .left_tag       (lt),
      .right_deadline (rd),
      .right_tag      (rt),
      .place          (cell_place[i]),
      .deadline       (cell_dl[i]),
      .tag            (cell_tag[i])
    );
  end

  // tick frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= FREQ_RESET;
    end else if (cfg_we) begin
      freq <= cfg_wdata;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      now     <= '0;
      compare <= '1;
      count   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.req_type == REQ_ADD) begin
              state <= (count == FULL_CNT) ? S_EMIT : S_MUL;
            end else begin
              state <= S_BUMP;
            end
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (is_add) begin
            state <= S_PLACE;
          end else begin
            compare <= now + prod;
            state   <= S_EMIT;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          if (cell_place[0]) begin
            compare <= dl;
          end
          state <= S_EMIT;
        end
        S_BUMP: begin
          now   <= now + TICK_W'(1);
          state <= S_TEST;
        end
        S_TEST: begin
          if (!due) begin
            state <= S_EMIT;
          end else if (count > CNT_W'(1)) begin
            count   <= count - CNT_W'(1);
            compare <= cell_dl[1];
            state   <= S_EMIT;
          end else begin
            // queue empty after this tick: idle reload
            if (count != '0) begin
              count <= count - CNT_W'(1);
            end
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request latch, datapath and result staging
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      is_add      <= (req.req_type == REQ_ADD);
      timeout_r   <= req.timeout;
      ticks_r     <= req.in_ticks;
      tag_r       <= req.event_tag;
      fired_r     <= 1'b0;
      fired_tag_r <= '0;
      rejected_r  <= (req.req_type == REQ_ADD) && (count == FULL_CNT);
    end
    if (state == S_MUL) begin
      prod <= (is_add && ticks_r) ? TICK_W'(timeout_r) : mul_p;
    end
    if (state == S_SUM) begin
      dl <= now + prod;
    end
    if (cmd.pop) begin
      fired_r     <= 1'b1;
      fired_tag_r <= cell_tag[0];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_EMIT && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && rsp_free) begin
      rsp.fired        <= fired_r;
      rsp.fired_tag    <= fired_tag_r;
      rsp.next_compare <= compare;
      rsp.queued_count <= count;
      rsp.rejected     <= rejected_r;
    end
  end

endmodule

FILE: rtl/core/stq_cell.sv
// stq_cell: one slot of the sorted queue; holds a deadline and a tag.
// Shifts right on insert behind the new entry, left on pop. Uses stq_pkg.
`timescale 1ns / 1ps

module stq_cell (
  input  logic                      clk,
  input  stq_pkg::stq_cmd_t         cmd,
  input  logic                      occupied,
  input  logic                      left_place,
  input  logic [stq_pkg::TICK_W-1:0] left_deadline,
  input  logic [stq_pkg::TAG_W-1:0]  left_tag,
  input  logic [stq_pkg::TICK_W-1:0] right_deadline,
  input  logic [stq_pkg::TAG_W-1:0]  right_tag,
  output logic                      place,
  output logic [stq_pkg::TICK_W-1:0] deadline,
  output logic [stq_pkg::TAG_W-1:0]  tag
);
  import stq_pkg::*;

  // new entry goes at or before this slot: empty slot or later deadline
  assign place = !occupied || (deadline > cmd.new_deadline);

  // slot contents
  always_ff @(posedge clk) begin
    if (cmd.insert && place) begin
      if (left_place) begin
        deadline <= left_deadline;
        tag      <= left_tag;
      end else begin
        deadline <= cmd.new_deadline;
        tag      <= cmd.new_tag;
      end
    end else if (cmd.pop) begin
      deadline <= right_deadline;
      tag      <= right_tag;
    end
  end

endmodule

FILE: dv/sorted_timer_event_queue_unit_test.sv
// Self-checking bench for sorted_timer_event_queue_unit: tick/add beats against a
// timer-queue predictor. Depends on stq_pkg, stq_if and the RTL under rtl/core.
`timescale 1ns / 1ps

module sorted_timer_event_queue_unit_test;
  import stq_pkg::*;

  localparam int QDEPTH         = 16;
  localparam int CNT_W          = 5;
  localparam int IDLE_RELOAD    = 10000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BEATS    = 110;

  typedef enum logic [1:0] {PACE_STEADY, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;
  typedef enum logic [1:0] {JOB_BEAT, JOB_CFG, JOB_PACE, JOB_HOLD} job_kind_t;

  typedef struct {
    job_kind_t         kind;
    logic              req_type;
    logic [FREQ_W-1:0] timeout;
    logic              in_ticks;
    logic [TAG_W-1:0]  event_tag;
    pace_t             pace;
  } job_t;

  typedef struct packed {
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
    logic [TICK_W-1:0] next_compare;
    logic [CNT_W-1:0]  queued_count;
    logic              rejected;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [FREQ_W-1:0] cfg_wdata;

  stq_req_if req_ch ();
  stq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

  sorted_timer_event_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timer queue shadow state
  logic [TICK_W-1:0] mdl_now;
  logic [TICK_W-1:0] mdl_compare;
  logic [TICK_W-1:0] mdl_deadline [QDEPTH];
  logic [TAG_W-1:0]  mdl_tag [QDEPTH];
  int                mdl_count;
  logic [FREQ_W-1:0] mdl_freq;

  job_t     pending_jobs[$];
  outcome_t expected_outcomes[$];
  job_t     on_bus;
  pace_t    pace = PACE_STEADY;
  int       issued_cnt = 0;
  int       results_seen = 0;
  int       settle_cnt = 0;
  int       error_count = 0;
  int       stuck_cycles = 0;
  int       far_budget = 6;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Applies one beat to the shadow queue and returns the result it should produce.
  function automatic outcome_t predict_timer_outcome(input job_t beat);
    outcome_t o;
    logic [TICK_W-1:0] dl;
    int pos;
    int i;
    o = '0;
    if (beat.req_type == REQ_ADD) begin
      if (mdl_count >= QDEPTH) begin
        o.rejected = 1'b1;
      end else begin
        dl = beat.in_ticks ? mdl_now + {32'd0, beat.timeout}
                           : mdl_now + {32'd0, mdl_freq} * {32'd0, beat.timeout};
        // new entry goes behind every equal deadline
        pos = 0;
        while (pos < mdl_count && mdl_deadline[pos] <= dl) pos++;
        for (i = mdl_count; i > pos; i--) begin
          mdl_deadline[i] = mdl_deadline[i-1];
          mdl_tag[i]      = mdl_tag[i-1];
        end
        mdl_deadline[pos] = dl;
        mdl_tag[pos]      = beat.event_tag;
        mdl_count++;
        if (pos == 0) mdl_compare = dl;
      end
    end else begin
      mdl_now = mdl_now + 64'd1;
      if (mdl_now >= mdl_compare) begin
        if (mdl_count > 0) begin
          o.fired     = 1'b1;
          o.fired_tag = mdl_tag[0];
          for (i = 1; i < mdl_count; i++) begin
            mdl_deadline[i-1] = mdl_deadline[i];
            mdl_tag[i-1]      = mdl_tag[i];
          end
          mdl_count--;
        end
        // empty queue falls back to the idle reload
        mdl_compare = (mdl_count > 0) ? mdl_deadline[0]
                    : mdl_now + {32'd0, mdl_freq} * 64'(IDLE_RELOAD);
      end
    end
    o.next_compare = mdl_compare;
    o.queued_count = CNT_W'(mdl_count);
    return o;
  endfunction

  function automatic bit pace_gap(input bit sink_side);
    int roll;
    roll = $urandom_range(0, 99);
    case (pace)
      PACE_SRC_GAPS:    return !sink_side && roll < 46;
      PACE_SINK_STALLS: return sink_side && roll < 46;
      PACE_BOTH:        return roll < 8;
      default:          return 1'b0;
    endcase
  endfunction

  task automatic push_job(input job_kind_t kind, input logic rt, input logic [FREQ_W-1:0] val,
                          input logic it, input logic [TAG_W-1:0] tg, input pace_t p);
    job_t j;
    j.kind      = kind;
    j.req_type  = rt;
    j.timeout   = val;
    j.in_ticks  = it;
    j.event_tag = tg;
    j.pace      = p;
    pending_jobs.push_back(j);
  endtask

  task automatic push_tick();
    push_job(JOB_BEAT, REQ_TICK, $urandom(), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)), PACE_STEADY);
  endtask

  // Mixed tick/add beats; timeouts kept near so events keep firing, a few far ones.
  task automatic push_random_beats(input int n, input int add_pct, input logic [FREQ_W-1:0] freq);
    logic [FREQ_W-1:0] tmo;
    logic by_ticks;
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        by_ticks = ($urandom_range(0, 99) < 70);
        if (far_budget > 0 && $urandom_range(0, 99) < 2) begin
          tmo = $urandom();
          far_budget--;
        end else if (by_ticks) begin
          tmo = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 400);
        end else if (freq <= 8) begin
          tmo = $urandom_range(0, 24 / freq);
        end else begin
          tmo = '0;
        end
        push_job(JOB_BEAT, REQ_ADD, tmo, by_ticks, 8'($urandom_range(0, 255)), PACE_STEADY);
      end else begin
        push_tick();
      end
    end
  endtask

  // Driver: launches beats, holds them until accepted, writes the register when idle
  always @(posedge clk) begin : driver
    logic next_valid;
    logic next_we;
    logic launch;
    job_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      cfg_we       <= 1'b0;
      settle_cnt = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_outcomes.push_back(predict_timer_outcome(on_bus));
        issued_cnt++;
      end
      next_valid = req_ch.valid && !req_ch.ready;
      next_we    = 1'b0;
      launch     = 1'b0;
      if (!next_valid && pending_jobs.size() > 0) begin
        case (pending_jobs[0].kind)
          JOB_PACE: begin
            pace = pending_jobs[0].pace;
            void'(pending_jobs.pop_front());
          end
          JOB_BEAT: begin
            if (!pace_gap(1'b0)) begin
              on_bus     = pending_jobs.pop_front();
              launch     = 1'b1;
              next_valid = 1'b1;
            end
          end
          default: begin
            // register writes and the hold both wait for an idle, settled block
            if (issued_cnt != results_seen) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
              settle_cnt++;
            end else begin
              nxt = pending_jobs.pop_front();
              settle_cnt = 0;
              if (nxt.kind == JOB_CFG) begin
                mdl_freq = nxt.timeout;
                next_we  = 1'b1;
                cfg_wdata <= nxt.timeout;
              end
            end
          end
        endcase
      end
      req_ch.valid <= next_valid;
      cfg_we       <= next_we;
      if (launch) begin
        req_ch.req_type  <= on_bus.req_type;
        req_ch.timeout   <= on_bus.timeout;
        req_ch.in_ticks  <= on_bus.in_ticks;
        req_ch.event_tag <= on_bus.event_tag;
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.fired !== want.fired)
            report_mismatch($sformatf("fired %b, want %b", rsp_ch.fired, want.fired));
          if (rsp_ch.fired_tag !== want.fired_tag)
            report_mismatch($sformatf("fired_tag %h, want %h", rsp_ch.fired_tag,
                                      want.fired_tag));
          if (rsp_ch.next_compare !== want.next_compare)
            report_mismatch($sformatf("next_compare %h, want %h", rsp_ch.next_compare,
                                      want.next_compare));
          if (rsp_ch.queued_count !== want.queued_count)
            report_mismatch($sformatf("queued_count %0d, want %0d", rsp_ch.queued_count,
                                      want.queued_count));
          if (rsp_ch.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, want %b", rsp_ch.rejected, want.rejected));
        end
      end
      rsp_ch.ready <= !pace_gap(1'b1);
    end
  end

  // Watchdog on cycles without any handshake or register write
  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] phase_freq [RAND_PHASES];
    int i;
    int p;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.timeout  = '0;
    req_ch.in_ticks = 1'b0;
    req_ch.event_tag = '0;
    rsp_ch.ready    = 1'b0;

    mdl_now     = '0;
    mdl_compare = '1;
    mdl_count   = 0;
    mdl_freq    = FREQ_RESET;

    // directed: reset frequency, no-expiry compare, equal deadlines, fill and overflow
    push_tick();
    push_job(JOB_BEAT, REQ_ADD, 32'd0, 1'b0, 8'h00, PACE_STEADY);
    push_job(JOB_BEAT, REQ_ADD, 32'd0, 1'b1, 8'hFF, PACE_STEADY);
    push_tick();
    push_tick();
    for (i = 0; i < QDEPTH; i++)
      push_job(JOB_BEAT, REQ_ADD, 32'(i % 5), 1'b1, 8'(8'h10 + i), PACE_STEADY);
    push_job(JOB_BEAT, REQ_ADD, 32'h1234_5678, 1'b0, 8'h5A, PACE_STEADY);

    // lowest frequency: drain the queue so compare falls back to the idle reload
    push_job(JOB_CFG, REQ_TICK, 32'd1, 1'b0, 8'h00, PACE_STEADY);
    for (i = 0; i < QDEPTH + 24; i++) push_tick();

    // far deadlines at the field maxima, equal to each other at this frequency
    push_job(JOB_BEAT, REQ_ADD, 32'hFFFF_FFFF, 1'b1, 8'hFF, PACE_STEADY);
    push_job(JOB_BEAT, REQ_ADD, 32'hFFFF_FFFF, 1'b0, 8'h00, PACE_STEADY);

    // random phases over frequencies and pacing
    phase_freq = '{32'd3, 32'hFFFF_FFFF, FREQ_RESET, 32'd2, 32'd1, 32'd5, 32'd1,
                   32'($urandom_range(1, 20))};
    for (p = 0; p < RAND_PHASES; p++) begin
      push_job(JOB_CFG, REQ_TICK, phase_freq[p], 1'b0, 8'h00, PACE_STEADY);
      push_job(JOB_PACE, REQ_TICK, 32'd0, 1'b0, 8'h00, pace_t'(p % 4));
      if (p == 4) begin
        push_random_beats(PHASE_BEATS / 2, 45, phase_freq[p]);
        push_job(JOB_HOLD, REQ_TICK, 32'd0, 1'b0, 8'h00, PACE_STEADY);
        push_random_beats(PHASE_BEATS / 2, 45, phase_freq[p]);
      end else begin
        push_random_beats(PHASE_BEATS, 35 + 4 * p, phase_freq[p]);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_jobs.size() != 0 || req_ch.valid || issued_cnt != results_seen);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", expected_outcomes.size()));

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
